[rtl/core/qrm_pkg.sv]
// Shared constants and word types for the quaternion to rotation matrix block.
`default_nettype none

package qrm_pkg;

    // Component width of every input and output entry (signed, Q1.(W-2)).
    localparam int unsigned COMPONENT_WIDTH = 16;

    // Matrix entries produced for each quaternion.
    localparam int unsigned NUM_ENTRIES = 9;

    // Positions of the entries, row major.
    localparam int unsigned E00 = 0;
    localparam int unsigned E01 = 1;
    localparam int unsigned E02 = 2;
    localparam int unsigned E10 = 3;
    localparam int unsigned E11 = 4;
    localparam int unsigned E12 = 5;
    localparam int unsigned E20 = 6;
    localparam int unsigned E21 = 7;
    localparam int unsigned E22 = 8;

    // 1.0 in the entry format.
    localparam logic signed [COMPONENT_WIDTH-1:0] UNIT_ONE =
        COMPONENT_WIDTH'(1) <<< (COMPONENT_WIDTH - 2);

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

    typedef struct packed {
        comp_t quat_x;
        comp_t quat_y;
        comp_t quat_z;
        comp_t quat_w;
    } quat_t;

    typedef struct packed {
        comp_t m00;
        comp_t m01;
        comp_t m02;
        comp_t m10;
        comp_t m11;
        comp_t m12;
        comp_t m20;
        comp_t m21;
        comp_t m22;
        logic  zero_norm;
    } matrix_t;

endpackage

`default_nettype wire

[rtl/core/quaternion_to_rotation_matrix_top.sv]
// Pipelined conversion of one quaternion per word into a 3x3 rotation matrix.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------
//  quat    | in        | quat_valid / quat_ready| qrm_pkg::quat_t (x, y, z, w)
//  mat     | out       | mat_valid / mat_ready  | qrm_pkg::matrix_t (m00..m22,
//          |           |                        | zero_norm)
//
//  Throughput is one word per cycle while mat_ready is high. The stages are
//  products, sums, magnitudes, one restoring-division stage per quotient bit
//  for all nine entries in parallel, then rounding.
//  rst_n clears every stage valid bit at once; the data registers keep junk.
//  A stall on mat fills bubbles first: a stage advances whenever any stage
//  at or after it is empty or mat_ready is high, so nothing is lost or doubled.
`default_nettype none

module quaternion_to_rotation_matrix_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             quat_valid,
    output logic             quat_ready,
    input  qrm_pkg::quat_t   quat,
    output logic             mat_valid,
    input  logic             mat_ready,
    output qrm_pkg::matrix_t mat
);
    import qrm_pkg::*;

    localparam int W    = COMPONENT_WIDTH;
    localparam int PW   = 2 * W;       // product width
    localparam int SW   = 2 * W + 2;   // signed numerator width
    localparam int NW   = 2 * W + 1;   // unsigned norm / magnitude width
    localparam int NE   = NUM_ENTRIES;
    localparam int DIV0 = 3;           // first division stage index
    localparam int NS   = W + 4;       // total register stages

    typedef struct packed {
        logic signed [PW-1:0] xx;
        logic signed [PW-1:0] yy;
        logic signed [PW-1:0] zz;
        logic signed [PW-1:0] ww;
        logic signed [PW-1:0] xy;
        logic signed [PW-1:0] xz;
        logic signed [PW-1:0] yz;
        logic signed [PW-1:0] wx;
        logic signed [PW-1:0] wy;
        logic signed [PW-1:0] wz;
    } prod_t;

    // Stage valid bits and advance enables.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    // Advance a stage when out is taken or it or any later stage holds a bubble.
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            en[i] = mat_ready | (|((~vld_reg) >> i));
        end
        vld_next[0] = quat_valid;
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign quat_ready = en[0];
    assign mat_valid  = vld_reg[NS-1];

    // Stage 0: all ten component products.
    prod_t prod_reg;
    prod_t prod_next;

    always_comb
    begin
        prod_next.xx = PW'(quat.quat_x * quat.quat_x);
        prod_next.yy = PW'(quat.quat_y * quat.quat_y);
        prod_next.zz = PW'(quat.quat_z * quat.quat_z);
        prod_next.ww = PW'(quat.quat_w * quat.quat_w);
        prod_next.xy = PW'(quat.quat_x * quat.quat_y);
        prod_next.xz = PW'(quat.quat_x * quat.quat_z);
        prod_next.yz = PW'(quat.quat_y * quat.quat_z);
        prod_next.wx = PW'(quat.quat_w * quat.quat_x);
        prod_next.wy = PW'(quat.quat_w * quat.quat_y);
        prod_next.wz = PW'(quat.quat_w * quat.quat_z);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 1: norm and the nine signed numerators.
    logic        [NW-1:0] norm_reg;
    logic signed [SW-1:0] norm_next;
    logic signed [SW-1:0] num_reg  [NE];
    logic signed [SW-1:0] num_next [NE];

    function automatic logic signed [SW-1:0] dbl(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b,
        input logic                 sub
    );
        logic signed [SW-1:0] s;
        s = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
        return {s[SW-2:0], 1'b0};
    endfunction

    always_comb
    begin
        norm_next = SW'(prod_reg.xx) + SW'(prod_reg.yy)
                  + SW'(prod_reg.zz) + SW'(prod_reg.ww);
        // Diagonal: n - 2(a + b) regrouped as a sum of four squares.
        num_next[E00] = SW'(prod_reg.xx) + SW'(prod_reg.ww)
                      - SW'(prod_reg.yy) - SW'(prod_reg.zz);
        num_next[E11] = SW'(prod_reg.yy) + SW'(prod_reg.ww)
                      - SW'(prod_reg.xx) - SW'(prod_reg.zz);
        num_next[E22] = SW'(prod_reg.zz) + SW'(prod_reg.ww)
                      - SW'(prod_reg.xx) - SW'(prod_reg.yy);
        num_next[E01] = dbl(prod_reg.xy, prod_reg.wz, 1'b0);
        num_next[E02] = dbl(prod_reg.xz, prod_reg.wy, 1'b1);
        num_next[E10] = dbl(prod_reg.xy, prod_reg.wz, 1'b1);
        num_next[E12] = dbl(prod_reg.yz, prod_reg.wx, 1'b0);
        num_next[E20] = dbl(prod_reg.xz, prod_reg.wy, 1'b0);
        num_next[E21] = dbl(prod_reg.yz, prod_reg.wx, 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            norm_reg <= norm_next[NW-1:0];
            num_reg  <= num_next;
        end
    end

    // Stage 2: magnitudes, signs and the zero-norm flag.
    logic [NW-1:0] amag_reg  [NE];
    logic [NW-1:0] amag_next [NE];
    logic [NE-1:0] aneg_reg;
    logic [NE-1:0] aneg_next;
    logic [NW-1:0] aden_reg;
    logic          azero_reg;

    always_comb
    begin
        for (int e = 0; e < NE; e++)
        begin
            logic signed [SW-1:0] neg_val;
            neg_val      = -num_reg[e];
            aneg_next[e] = num_reg[e][SW-1];
            amag_next[e] = num_reg[e][SW-1] ? neg_val[NW-1:0] : num_reg[e][NW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            amag_reg  <= amag_next;
            aneg_reg  <= aneg_next;
            aden_reg  <= norm_reg;
            azero_reg <= (norm_reg == '0);
        end
    end

    // Division stages: one quotient bit per stage for every entry.
    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [NW-1:0] drem_reg [NE];
        logic [W-1:0]  dq_reg   [NE];
        logic [NW-1:0] dden_reg;
        logic [NE-1:0] dneg_reg;
        logic          dzero_reg;
        logic [NW-1:0] rem_in  [NE];
        logic [W-1:0]  q_in    [NE];
        logic [NW-1:0] den_in;
        logic [NE-1:0] neg_in;
        logic          zero_in;
        logic [NW-1:0] rem_next [NE];
        logic [W-1:0]  q_next   [NE];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int e = 0; e < NE; e++)
                begin
                    rem_in[e] = amag_reg[e];
                    q_in[e]   = '0;
                end
                den_in  = aden_reg;
                neg_in  = aneg_reg;
                zero_in = azero_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int e = 0; e < NE; e++)
                begin
                    rem_in[e] = g_div[k-1].drem_reg[e];
                    q_in[e]   = g_div[k-1].dq_reg[e];
                end
                den_in  = g_div[k-1].dden_reg;
                neg_in  = g_div[k-1].dneg_reg;
                zero_in = g_div[k-1].dzero_reg;
            end
        end

        // Trial subtract; keep the difference when it does not go negative.
        always_comb
        begin
            for (int e = 0; e < NE; e++)
            begin
                logic [NW:0]   trial;
                logic [NW+1:0] diff;
                trial = (k == 0) ? {1'b0, rem_in[e]} : {rem_in[e], 1'b0};
                diff  = {1'b0, trial} - {2'b00, den_in};
                rem_next[e] = diff[NW+1] ? trial[NW-1:0] : diff[NW-1:0];
                q_next[e]   = {q_in[e][W-2:0], ~diff[NW+1]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[DIV0+k])
            begin
                drem_reg  <= rem_next;
                dq_reg    <= q_next;
                dden_reg  <= den_in;
                dneg_reg  <= neg_in;
                dzero_reg <= zero_in;
            end
        end
    end

    // Output stage: round half away from zero, restore sign, clamp, identity.
    comp_t   res [NE];
    matrix_t mat_reg;
    matrix_t mat_next;

    always_comb
    begin
        for (int e = 0; e < NE; e++)
        begin
            logic        [W:0]   qp1;
            logic        [W-1:0] mag;
            logic signed [W:0]   val;
            qp1 = {1'b0, g_div[W-1].dq_reg[e]} + (W+1)'(1);
            mag = qp1[W:1];
            val = g_div[W-1].dneg_reg[e] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (val[W] != val[W-1])
            begin
                res[e] = val[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                res[e] = val[W-1:0];
            end
            if (g_div[W-1].dzero_reg)
            begin
                res[e] = (e == E00 || e == E11 || e == E22) ? UNIT_ONE : '0;
            end
        end
        mat_next.m00       = res[E00];
        mat_next.m01       = res[E01];
        mat_next.m02       = res[E02];
        mat_next.m10       = res[E10];
        mat_next.m11       = res[E11];
        mat_next.m12       = res[E12];
        mat_next.m20       = res[E20];
        mat_next.m21       = res[E21];
        mat_next.m22       = res[E22];
        mat_next.zero_norm = g_div[W-1].dzero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

[rtl/core/qrm_checker.sv]
// Port-level checks for the quaternion to rotation matrix block, with its bind.
`default_nettype none

module qrm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             quat_ready,
    input logic             mat_valid,
    input logic             mat_ready,
    input qrm_pkg::matrix_t mat
);
    import qrm_pkg::*;

    function automatic logic in_unit(input comp_t v);
        return (v <= UNIT_ONE) && (v >= -UNIT_ONE);
    endfunction

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !mat_valid)
        else $error("result word valid during reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_ready |=> mat_valid && $stable(mat))
        else $error("stalled result word changed");

    // A taken output lets the whole pipe advance.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        mat_ready |-> quat_ready)
        else $error("input stalled while output is taken");

    // Zero norm returns the identity matrix.
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat.zero_norm |->
            mat.m00 == UNIT_ONE && mat.m11 == UNIT_ONE && mat.m22 == UNIT_ONE &&
            mat.m01 == '0 && mat.m02 == '0 && mat.m10 == '0 &&
            mat.m12 == '0 && mat.m20 == '0 && mat.m21 == '0)
        else $error("zero norm without identity matrix");

    // Rotation entries never leave [-1.0, 1.0].
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid |->
            in_unit(mat.m00) && in_unit(mat.m01) && in_unit(mat.m02) &&
            in_unit(mat.m10) && in_unit(mat.m11) && in_unit(mat.m12) &&
            in_unit(mat.m20) && in_unit(mat.m21) && in_unit(mat.m22))
        else $error("matrix entry outside unit range");

endmodule

bind quaternion_to_rotation_matrix_top qrm_checker u_qrm_checker (.*);

`default_nettype wire
